@@ rtl/core/nfcs_pkg.sv @@
// Shared types and constants of the NOR flash command sequencer.
package nfcs_pkg;

    localparam int ADDR_W  = 24;
    localparam int DATA_W  = 16;
    localparam int LIMIT_W = 24;
    localparam int STEP_W  = 3;
    localparam int SEQ_W   = 3;

    // input operations
    localparam logic [1:0] OP_CHIP_ERASE   = 2'd0;
    localparam logic [1:0] OP_SECTOR_ERASE = 2'd1;
    localparam logic [1:0] OP_PROGRAM      = 2'd2;
    localparam logic [1:0] OP_READ_DATA    = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // completion status
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ERROR   = 2'd1;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

    // bus cycle constants
    localparam logic [ADDR_W-1:0] UNLOCK_ADDR_1 = 24'h000555;
    localparam logic [ADDR_W-1:0] UNLOCK_ADDR_2 = 24'h0002AA;
    localparam logic [DATA_W-1:0] UNLOCK_DATA_1 = 16'h00AA;
    localparam logic [DATA_W-1:0] UNLOCK_DATA_2 = 16'h0055;
    localparam logic [DATA_W-1:0] CMD_ERASE     = 16'h0080;
    localparam logic [DATA_W-1:0] CMD_CHIP      = 16'h0010;
    localparam logic [DATA_W-1:0] CMD_SECTOR    = 16'h0030;
    localparam logic [DATA_W-1:0] CMD_PROGRAM   = 16'h00A0;
    localparam logic [DATA_W-1:0] CMD_RESET     = 16'h00F0;
    localparam logic [DATA_W-1:0] TOGGLE_MASK   = 16'h0044;
    localparam logic [DATA_W-1:0] DQ5_MASK      = 16'h0020;

    // result sequences played by the emitter
    localparam logic [SEQ_W-1:0] SEQ_ERASE_CHIP   = 3'd0;
    localparam logic [SEQ_W-1:0] SEQ_ERASE_SECTOR = 3'd1;
    localparam logic [SEQ_W-1:0] SEQ_PROGRAM      = 3'd2;
    localparam logic [SEQ_W-1:0] SEQ_READ         = 3'd3;
    localparam logic [SEQ_W-1:0] SEQ_DONE         = 3'd4;
    localparam logic [SEQ_W-1:0] SEQ_ABORT        = 3'd5;

    typedef struct packed {
        logic              start;
        logic [SEQ_W-1:0]  seq;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
    } burst_t;

    function automatic logic [STEP_W-1:0] seq_last_step(input logic [SEQ_W-1:0] seq);
        logic [STEP_W-1:0] r;
        case (seq)
            SEQ_ERASE_CHIP,
            SEQ_ERASE_SECTOR: r = 3'd6;
            SEQ_PROGRAM:      r = 3'd4;
            SEQ_ABORT:        r = 3'd1;
            default:          r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/nfcs_channels.sv @@
// Handshake channel interfaces: command/read-data input, result output, configuration.
interface nfcs_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  operation;
    logic [nfcs_pkg::ADDR_W-1:0] target_address;
    logic [nfcs_pkg::DATA_W-1:0] write_halfword;
    logic [nfcs_pkg::DATA_W-1:0] read_halfword;
    logic                        last_word;

    modport source (output valid, operation, target_address, write_halfword,
                    read_halfword, last_word, input ready);
    modport sink   (input valid, operation, target_address, write_halfword,
                    read_halfword, last_word, output ready);
endinterface

interface nfcs_res_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  result_kind;
    logic [nfcs_pkg::ADDR_W-1:0] bus_address;
    logic [nfcs_pkg::DATA_W-1:0] bus_data;
    logic [1:0]                  done_status;
    logic                        run_last;

    modport source (output valid, result_kind, bus_address, bus_data, done_status,
                    run_last, input ready);
    modport sink   (input valid, result_kind, bus_address, bus_data, done_status,
                    run_last, output ready);
endinterface

interface nfcs_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [nfcs_pkg::LIMIT_W-1:0] poll_limit;

    modport source (output valid, poll_limit, input ready);
    modport sink   (input valid, poll_limit, output ready);
endinterface

@@ rtl/core/nfcs_ctrl.sv @@
// Command decode, toggle-bit poll state machine and run bookkeeping.
module nfcs_ctrl #(
    parameter int ADDR_BITS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    nfcs_cmd_if.sink         cmd,
    nfcs_cfg_if.sink         cfg,
    input  logic             free,
    output nfcs_pkg::burst_t burst
);
    localparam int HA_W = (ADDR_BITS < nfcs_pkg::ADDR_W) ? ADDR_BITS : nfcs_pkg::ADDR_W;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_VERIFY = 3'd1;
    localparam logic [2:0] PH_POLL_A = 3'd2;
    localparam logic [2:0] PH_POLL_B = 3'd3;
    localparam logic [2:0] PH_POLL_C = 3'd4;
    localparam logic [2:0] PH_POLL_D = 3'd5;

    logic [2:0]                    phase_reg, phase_next;
    logic [1:0]                    command_reg, command_next;
    logic [HA_W-1:0]               held_addr_reg, held_addr_next;
    logic [nfcs_pkg::DATA_W-1:0]   held_data_reg, held_data_next;
    logic [nfcs_pkg::DATA_W-1:0]   first_reg, first_next;
    logic [nfcs_pkg::LIMIT_W-1:0]  polls_reg, polls_next;
    logic [nfcs_pkg::LIMIT_W-1:0]  limit_reg;
    logic                          aborted_reg, aborted_next;
    logic                          held_last_reg, held_last_next;

    logic                          accept;
    logic [HA_W-1:0]               tgt;
    logic [nfcs_pkg::ADDR_W-1:0]   held_addr_ext;
    logic                          fail;
    logic [1:0]                    fail_status;
    logic                          round_end;
    logic                          toggle_same;

    assign cmd.ready     = free;
    assign cfg.ready     = 1'b1;
    assign accept        = cmd.valid && free;
    assign tgt           = HA_W'(cmd.target_address);
    assign held_addr_ext = nfcs_pkg::ADDR_W'(held_addr_reg);
    assign toggle_same   = (first_reg & nfcs_pkg::TOGGLE_MASK)
                           == (cmd.read_halfword & nfcs_pkg::TOGGLE_MASK);

    always_comb
    begin
        phase_next     = phase_reg;
        command_next   = command_reg;
        held_addr_next = held_addr_reg;
        held_data_next = held_data_reg;
        first_next     = first_reg;
        polls_next     = polls_reg;
        aborted_next   = aborted_reg;
        held_last_next = held_last_reg;
        fail           = 1'b0;
        fail_status    = nfcs_pkg::STATUS_TIMEOUT;
        round_end      = 1'b0;
        burst          = '{start: 1'b0, seq: nfcs_pkg::SEQ_READ, addr: held_addr_ext,
                           data: '0, status: nfcs_pkg::STATUS_OK};

        if (accept)
        begin
            if (cmd.operation != nfcs_pkg::OP_READ_DATA)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (cmd.operation == nfcs_pkg::OP_PROGRAM)
                    begin
                        if (aborted_reg)
                        begin
                            // words of a failed run are dropped up to its last one
                            if (cmd.last_word)
                                aborted_next = 1'b0;
                        end
                        else
                        begin
                            command_next   = nfcs_pkg::OP_PROGRAM;
                            held_addr_next = tgt;
                            held_data_next = cmd.write_halfword;
                            held_last_next = cmd.last_word;
                            phase_next     = PH_VERIFY;
                            burst.start    = 1'b1;
                            burst.addr     = nfcs_pkg::ADDR_W'(tgt);
                        end
                    end
                    else
                    begin
                        aborted_next   = 1'b0;
                        command_next   = cmd.operation;
                        held_last_next = 1'b0;
                        polls_next     = limit_reg;
                        phase_next     = PH_POLL_A;
                        burst.start    = 1'b1;
                        if (cmd.operation == nfcs_pkg::OP_CHIP_ERASE)
                        begin
                            held_addr_next = '0;
                            burst.seq      = nfcs_pkg::SEQ_ERASE_CHIP;
                            burst.addr     = '0;
                        end
                        else
                        begin
                            held_addr_next = tgt;
                            burst.seq      = nfcs_pkg::SEQ_ERASE_SECTOR;
                            burst.addr     = nfcs_pkg::ADDR_W'(tgt);
                        end
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_VERIFY:
                    begin
                        burst.start = 1'b1;
                        if (cmd.read_halfword == held_data_reg)
                        begin
                            phase_next = PH_IDLE;
                            burst.seq  = nfcs_pkg::SEQ_DONE;
                        end
                        else
                        begin
                            polls_next = limit_reg;
                            phase_next = PH_POLL_A;
                            burst.seq  = nfcs_pkg::SEQ_PROGRAM;
                            burst.data = held_data_reg;
                        end
                    end
                    PH_POLL_A, PH_POLL_C:
                    begin
                        first_next  = cmd.read_halfword;
                        phase_next  = (phase_reg == PH_POLL_A) ? PH_POLL_B : PH_POLL_D;
                        burst.start = 1'b1;
                    end
                    PH_POLL_B:
                    begin
                        if (toggle_same)
                        begin
                            phase_next  = PH_IDLE;
                            burst.start = 1'b1;
                            burst.seq   = nfcs_pkg::SEQ_DONE;
                        end
                        else if ((first_reg & nfcs_pkg::DQ5_MASK) != '0)
                        begin
                            // DQ5 up: one more pair decides between busy and error
                            phase_next  = PH_POLL_C;
                            burst.start = 1'b1;
                        end
                        else
                            round_end = 1'b1;
                    end
                    PH_POLL_D:
                    begin
                        if (!toggle_same)
                        begin
                            fail        = 1'b1;
                            fail_status = nfcs_pkg::STATUS_ERROR;
                        end
                        else
                            round_end = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase

                if (round_end)
                begin
                    if (polls_reg <= nfcs_pkg::LIMIT_W'(1))
                    begin
                        polls_next = '0;
                        fail       = 1'b1;
                    end
                    else
                    begin
                        polls_next  = polls_reg - nfcs_pkg::LIMIT_W'(1);
                        phase_next  = PH_POLL_A;
                        burst.start = 1'b1;
                    end
                end

                if (fail)
                begin
                    phase_next  = PH_IDLE;
                    burst.start = 1'b1;
                    if (command_reg == nfcs_pkg::OP_PROGRAM)
                    begin
                        burst.seq    = nfcs_pkg::SEQ_ABORT;
                        burst.status = nfcs_pkg::STATUS_TIMEOUT;
                        if (!held_last_reg)
                            aborted_next = 1'b1;
                    end
                    else
                    begin
                        burst.seq    = nfcs_pkg::SEQ_DONE;
                        burst.status = fail_status;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            command_reg   <= nfcs_pkg::OP_CHIP_ERASE;
            held_addr_reg <= '0;
            held_data_reg <= '0;
            first_reg     <= '0;
            polls_reg     <= '0;
            aborted_reg   <= 1'b0;
            held_last_reg <= 1'b0;
            limit_reg     <= '1;
        end
        else
        begin
            phase_reg     <= phase_next;
            command_reg   <= command_next;
            held_addr_reg <= held_addr_next;
            held_data_reg <= held_data_next;
            first_reg     <= first_next;
            polls_reg     <= polls_next;
            aborted_reg   <= aborted_next;
            held_last_reg <= held_last_next;
            if (cfg.valid)
                limit_reg <= cfg.poll_limit;
        end
    end

endmodule

@@ rtl/core/nfcs_emit.sv @@
// Result register: plays out one burst of bus cycles, one word per cycle while res.ready is high.
module nfcs_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  nfcs_pkg::burst_t burst,
    nfcs_res_if.source       res,
    output logic             free
);
    logic                                busy_reg;
    logic [nfcs_pkg::SEQ_W-1:0]          seq_reg;
    logic [nfcs_pkg::STEP_W-1:0]         step_reg;
    logic [nfcs_pkg::ADDR_W-1:0]         addr_reg;
    logic [nfcs_pkg::DATA_W-1:0]         data_reg;
    logic [1:0]                          status_reg;
    logic                                at_last;
    logic                                take;

    assign at_last   = step_reg == nfcs_pkg::seq_last_step(seq_reg);
    assign take      = busy_reg && res.ready;
    assign free      = !busy_reg || (take && at_last);
    assign res.valid = busy_reg;
    assign res.run_last = at_last;

    always_comb
    begin
        res.result_kind = nfcs_pkg::KIND_WRITE;
        res.bus_address = '0;
        res.bus_data    = '0;
        res.done_status = nfcs_pkg::STATUS_OK;
        case (seq_reg)
            nfcs_pkg::SEQ_ERASE_CHIP, nfcs_pkg::SEQ_ERASE_SECTOR, nfcs_pkg::SEQ_PROGRAM:
            begin
                case (step_reg)
                    3'd0, 3'd3:
                    begin
                        res.bus_address = nfcs_pkg::UNLOCK_ADDR_1;
                        res.bus_data    = nfcs_pkg::UNLOCK_DATA_1;
                        if (step_reg == 3'd3 && seq_reg == nfcs_pkg::SEQ_PROGRAM)
                        begin
                            res.bus_address = addr_reg;
                            res.bus_data    = data_reg;
                        end
                    end
                    3'd1, 3'd4:
                    begin
                        res.bus_address = nfcs_pkg::UNLOCK_ADDR_2;
                        res.bus_data    = nfcs_pkg::UNLOCK_DATA_2;
                        if (step_reg == 3'd4 && seq_reg == nfcs_pkg::SEQ_PROGRAM)
                        begin
                            res.result_kind = nfcs_pkg::KIND_READ;
                            res.bus_address = addr_reg;
                            res.bus_data    = '0;
                        end
                    end
                    3'd2:
                    begin
                        res.bus_address = nfcs_pkg::UNLOCK_ADDR_1;
                        res.bus_data    = (seq_reg == nfcs_pkg::SEQ_PROGRAM)
                                          ? nfcs_pkg::CMD_PROGRAM : nfcs_pkg::CMD_ERASE;
                    end
                    3'd5:
                    begin
                        if (seq_reg == nfcs_pkg::SEQ_ERASE_CHIP)
                        begin
                            res.bus_address = nfcs_pkg::UNLOCK_ADDR_1;
                            res.bus_data    = nfcs_pkg::CMD_CHIP;
                        end
                        else
                        begin
                            res.bus_address = addr_reg;
                            res.bus_data    = nfcs_pkg::CMD_SECTOR;
                        end
                    end
                    default:
                    begin
                        res.result_kind = nfcs_pkg::KIND_READ;
                        res.bus_address = addr_reg;
                    end
                endcase
            end
            nfcs_pkg::SEQ_READ:
            begin
                res.result_kind = nfcs_pkg::KIND_READ;
                res.bus_address = addr_reg;
            end
            nfcs_pkg::SEQ_ABORT:
            begin
                if (step_reg == 3'd0)
                    res.bus_data = nfcs_pkg::CMD_RESET;
                else
                begin
                    res.result_kind = nfcs_pkg::KIND_DONE;
                    res.done_status = status_reg;
                end
            end
            default:
            begin
                res.result_kind = nfcs_pkg::KIND_DONE;
                res.done_status = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            seq_reg  <= nfcs_pkg::SEQ_READ;
            step_reg <= '0;
        end
        else if (burst.start)
        begin
            busy_reg <= 1'b1;
            seq_reg  <= burst.seq;
            step_reg <= '0;
        end
        else if (take)
        begin
            if (at_last)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg + nfcs_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst.start)
        begin
            addr_reg   <= burst.addr;
            data_reg   <= burst.data;
            status_reg <= burst.status;
        end
    end

endmodule

@@ rtl/core/nor_flash_command_sequencer.sv @@
// NOR flash command sequencer top level: control state machine and result emitter.
// Each accepted word is decoded in the cycle it is taken and its bus cycles are played
// from the result register, one word per cycle while ready is high: a returned poll
// read, a verify read or a plain completion gives one word, a failed program two, a
// program start five and an erase seven. The next input word is taken in the cycle the
// last result of the previous one leaves, so back-to-back poll reads run at one word
// per clock; words that cause no result are taken whenever the result register is free.
// poll_limit resets to 0xFFFFFF and may be written on cfg while the block is idle.
module nor_flash_command_sequencer #(
    parameter int ADDR_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    nfcs_cmd_if.sink   cmd,
    nfcs_res_if.source res,
    nfcs_cfg_if.sink   cfg
);
    nfcs_pkg::burst_t burst;
    logic             free;

    nfcs_ctrl #(
        .ADDR_BITS (ADDR_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .cfg   (cfg),
        .free  (free),
        .burst (burst)
    );

    nfcs_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .burst (burst),
        .res   (res),
        .free  (free)
    );

endmodule

@@ tb/nfcs_bus_cycle_checker.sv @@
// Checker for the NOR flash command sequencer: predicts bus cycles from accepted words and compares.
module nfcs_bus_cycle_checker
    import nfcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    nfcs_cmd_if  cmd,
    nfcs_res_if  res,
    nfcs_cfg_if  cfg,
    output int   errors,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
        logic              last;
    } bus_cycle_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_VERIFY,
        SQ_FIRST_A,
        SQ_FIRST_B,
        SQ_SECOND_A,
        SQ_SECOND_B
    } seq_state_t;

    logic [LIMIT_W-1:0] limit_copy;
    seq_state_t         state;
    logic [1:0]         command;
    logic [ADDR_W-1:0]  held_addr;
    logic [DATA_W-1:0]  held_data;
    logic [DATA_W-1:0]  first_sample;
    logic [LIMIT_W-1:0] rounds_left;
    logic               dropping;
    logic               final_word;

    bus_cycle_t word_cycles[$];
    bus_cycle_t pending_cycles[$];

    function automatic void reset_model();
        limit_copy   = '1;
        state        = SQ_IDLE;
        command      = OP_CHIP_ERASE;
        held_addr    = '0;
        held_data    = '0;
        first_sample = '0;
        rounds_left  = '0;
        dropping     = 1'b0;
        final_word   = 1'b0;
        pending_cycles.delete();
        errors       = 0;
        outstanding  = 0;
    endfunction

    function automatic void emit_cycle(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                                       input logic [DATA_W-1:0] data, input logic [1:0] status);
        bus_cycle_t c;
        c.kind   = kind;
        c.addr   = addr;
        c.data   = data;
        c.status = status;
        c.last   = 1'b0;
        word_cycles.push_back(c);
    endfunction

    function automatic void emit_unlock(input logic [DATA_W-1:0] code);
        emit_cycle(KIND_WRITE, UNLOCK_ADDR_1, UNLOCK_DATA_1, STATUS_OK);
        emit_cycle(KIND_WRITE, UNLOCK_ADDR_2, UNLOCK_DATA_2, STATUS_OK);
        emit_cycle(KIND_WRITE, UNLOCK_ADDR_1, code, STATUS_OK);
    endfunction

    // a failed program always reports timeout, after a reset write
    function automatic void give_up(input logic [1:0] status);
        if (command == OP_PROGRAM)
        begin
            emit_cycle(KIND_WRITE, '0, CMD_RESET, STATUS_OK);
            emit_cycle(KIND_DONE, '0, '0, STATUS_TIMEOUT);
            if (!final_word)
                dropping = 1'b1;
        end
        else
            emit_cycle(KIND_DONE, '0, '0, status);
        state = SQ_IDLE;
    endfunction

    function automatic void end_round();
        if (rounds_left <= 1)
        begin
            rounds_left = '0;
            give_up(STATUS_TIMEOUT);
        end
        else
        begin
            rounds_left = rounds_left - 1'b1;
            state = SQ_FIRST_A;
            emit_cycle(KIND_READ, held_addr, '0, STATUS_OK);
        end
    endfunction

    function automatic void predict_bus_cycles(input logic [1:0] op,
                                               input logic [ADDR_W-1:0] tgt,
                                               input logic [DATA_W-1:0] wdata,
                                               input logic [DATA_W-1:0] rdata,
                                               input logic lastw);
        word_cycles.delete();
        if (op != OP_READ_DATA)
        begin
            if (state == SQ_IDLE)
            begin
                if (op == OP_PROGRAM)
                begin
                    if (dropping)
                    begin
                        if (lastw)
                            dropping = 1'b0;
                    end
                    else
                    begin
                        command    = OP_PROGRAM;
                        held_addr  = tgt;
                        held_data  = wdata;
                        final_word = lastw;
                        state      = SQ_VERIFY;
                        emit_cycle(KIND_READ, tgt, '0, STATUS_OK);
                    end
                end
                else
                begin
                    dropping   = 1'b0;
                    command    = op;
                    held_addr  = (op == OP_CHIP_ERASE) ? '0 : tgt;
                    final_word = 1'b0;
                    emit_unlock(CMD_ERASE);
                    emit_cycle(KIND_WRITE, UNLOCK_ADDR_1, UNLOCK_DATA_1, STATUS_OK);
                    emit_cycle(KIND_WRITE, UNLOCK_ADDR_2, UNLOCK_DATA_2, STATUS_OK);
                    if (op == OP_CHIP_ERASE)
                        emit_cycle(KIND_WRITE, UNLOCK_ADDR_1, CMD_CHIP, STATUS_OK);
                    else
                        emit_cycle(KIND_WRITE, held_addr, CMD_SECTOR, STATUS_OK);
                    rounds_left = limit_copy;
                    state = SQ_FIRST_A;
                    emit_cycle(KIND_READ, held_addr, '0, STATUS_OK);
                end
            end
        end
        else
        begin
            case (state)
                SQ_VERIFY:
                    if (rdata == held_data)
                    begin
                        state = SQ_IDLE;
                        emit_cycle(KIND_DONE, '0, '0, STATUS_OK);
                    end
                    else
                    begin
                        emit_unlock(CMD_PROGRAM);
                        emit_cycle(KIND_WRITE, held_addr, held_data, STATUS_OK);
                        rounds_left = limit_copy;
                        state = SQ_FIRST_A;
                        emit_cycle(KIND_READ, held_addr, '0, STATUS_OK);
                    end
                SQ_FIRST_A, SQ_SECOND_A:
                begin
                    first_sample = rdata;
                    state = (state == SQ_FIRST_A) ? SQ_FIRST_B : SQ_SECOND_B;
                    emit_cycle(KIND_READ, held_addr, '0, STATUS_OK);
                end
                SQ_FIRST_B:
                    if ((first_sample & TOGGLE_MASK) == (rdata & TOGGLE_MASK))
                    begin
                        state = SQ_IDLE;
                        emit_cycle(KIND_DONE, '0, '0, STATUS_OK);
                    end
                    else if ((first_sample & DQ5_MASK) != '0)
                    begin
                        state = SQ_SECOND_A;
                        emit_cycle(KIND_READ, held_addr, '0, STATUS_OK);
                    end
                    else
                        end_round();
                SQ_SECOND_B:
                    if ((first_sample & TOGGLE_MASK) != (rdata & TOGGLE_MASK))
                        give_up(STATUS_ERROR);
                    else
                        end_round();
                default:
                    ;
            endcase
        end
        if (word_cycles.size() > 0)
        begin
            word_cycles[word_cycles.size() - 1].last = 1'b1;
            foreach (word_cycles[i])
                pending_cycles.push_back(word_cycles[i]);
        end
    endfunction

    function automatic void report_mismatch(input string what, input bus_cycle_t want,
                                            input bus_cycle_t seen);
        errors++;
        if (errors <= 10)
        begin
            $display("%0t %s: expected kind %0d addr %h data %h status %0d last %0d",
                     $time, what, want.kind, want.addr, want.data, want.status, want.last);
            $display("%0t %s: got      kind %0d addr %h data %h status %0d last %0d",
                     $time, what, seen.kind, seen.addr, seen.data, seen.status, seen.last);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bus_cycle_t seen;
        bus_cycle_t want;
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                limit_copy = cfg.poll_limit;
            if (cmd.valid && cmd.ready)
                predict_bus_cycles(cmd.operation, cmd.target_address, cmd.write_halfword,
                                   cmd.read_halfword, cmd.last_word);
            if (res.valid && res.ready)
            begin
                seen.kind   = res.result_kind;
                seen.addr   = res.bus_address;
                seen.data   = res.bus_data;
                seen.status = res.done_status;
                seen.last   = res.run_last;
                if (pending_cycles.size() == 0)
                    report_mismatch("word with nothing pending", '0, seen);
                else
                begin
                    want = pending_cycles.pop_front();
                    if (seen.kind !== want.kind || seen.addr !== want.addr
                        || seen.data !== want.data || seen.status !== want.status
                        || seen.last !== want.last)
                        report_mismatch("wrong word", want, seen);
                end
            end
            outstanding = pending_cycles.size();
        end
    end

endmodule

@@ tb/nor_flash_command_sequencer_tb.sv @@
// Testbench top for the NOR flash command sequencer: clock, reset, stimulus and verdict.
module nor_flash_command_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nfcs_pkg::*;

    localparam int CYCLE_LIMIT = 800000;
    localparam int LONG_STALL  = 400;
    localparam int PHASE_WORDS = 100;

    logic clk = 1'b0;
    logic rst_n;

    int tx_idle;
    int rx_idle;
    bit hold_off_req;
    bit hold_off_done;
    int cycle_count = 0;
    int sent_words = 0;

    int errors;
    int outstanding;

    nfcs_cmd_if cmd ();
    nfcs_res_if res ();
    nfcs_cfg_if cfg ();

    nor_flash_command_sequencer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res),
        .cfg   (cfg)
    );

    nfcs_bus_cycle_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .res         (res),
        .cfg         (cfg),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result sink: random back-pressure plus one long hold-off on request
    initial
    begin
        res.ready = 1'b0;
        hold_off_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                res.ready <= 1'b0;
                repeat (LONG_STALL) @(negedge clk);
            end
            res.ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata, input logic [DATA_W-1:0] rdata,
                             input logic lastw);
        while ($urandom_range(0, 99) < tx_idle)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid          <= 1'b1;
        cmd.operation      <= op;
        cmd.target_address <= addr;
        cmd.write_halfword <= wdata;
        cmd.read_halfword  <= rdata;
        cmd.last_word      <= lastw;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sent_words++;
        @(negedge clk);
    endtask

    task automatic send_read(input logic [DATA_W-1:0] rdata);
        send_word(OP_READ_DATA, ADDR_W'($urandom), DATA_W'($urandom), rdata,
                  1'($urandom));
    endtask

    task automatic set_poll_limit(input logic [LIMIT_W-1:0] value);
        cfg.valid      <= 1'b1;
        cfg.poll_limit <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // zero reads finish any verify or poll in progress; then wait for every word out
    task automatic settle();
        repeat (8) send_read('0);
        cmd.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    // toggle bits either repeat the previous read or flip; settle_pct sets the odds
    task automatic poll_reads(input int count, input int settle_pct);
        logic [DATA_W-1:0] prev;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] flip_mask;
        prev = DATA_W'($urandom);
        repeat (count)
        begin
            value = DATA_W'($urandom);
            flip_mask = '0;
            if ($urandom_range(0, 99) >= settle_pct)
                while (flip_mask == '0)
                    flip_mask = DATA_W'($urandom) & TOGGLE_MASK;
            value = (value & ~TOGGLE_MASK) | ((prev ^ flip_mask) & TOGGLE_MASK);
            send_read(value);
            prev = value;
        end
    endtask

    task automatic random_sequence();
        int pick;
        int run_words;
        int settle_pct;
        logic [DATA_W-1:0] data;
        pick = $urandom_range(0, 99);
        settle_pct = $urandom_range(15, 60);
        if (pick < 45)
        begin
            run_words = $urandom_range(1, 3);
            for (int i = 0; i < run_words; i++)
            begin
                data = DATA_W'($urandom);
                send_word(OP_PROGRAM, ADDR_W'($urandom), data, DATA_W'($urandom),
                          i == run_words - 1);
                send_read(($urandom_range(0, 99) < 40) ? data : DATA_W'($urandom));
                if ($urandom_range(0, 99) < 85)
                    poll_reads($urandom_range(0, 8), settle_pct);
            end
        end
        else if (pick < 70)
        begin
            send_word(OP_SECTOR_ERASE, ADDR_W'($urandom), DATA_W'($urandom),
                      DATA_W'($urandom), 1'($urandom));
            poll_reads($urandom_range(0, 10), settle_pct);
        end
        else if (pick < 85)
        begin
            send_word(OP_CHIP_ERASE, ADDR_W'($urandom), DATA_W'($urandom),
                      DATA_W'($urandom), 1'($urandom));
            poll_reads($urandom_range(0, 10), settle_pct);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                send_word(2'($urandom), ADDR_W'($urandom), DATA_W'($urandom),
                          DATA_W'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_directed();
        // reset value of the poll limit still in force
        send_read(16'h1234);
        send_word(OP_CHIP_ERASE, '1, '1, '1, 1'b1);
        send_read(16'h0044);
        send_read(16'h0044);
        send_word(OP_PROGRAM, '1, '1, '0, 1'b1);
        send_read(16'hFFFF);
        settle();
        set_poll_limit('0);
        // last word of a run fails: timeout, nothing dropped after it
        send_word(OP_PROGRAM, 24'h123456, 16'hA5A5, '0, 1'b1);
        send_read('0);
        send_read(16'h0004);
        send_read(16'h0040);
        // DQ5 set, second pair agrees: round ends, run aborted
        send_word(OP_PROGRAM, '0, 16'h0001, '1, 1'b0);
        send_read(16'hFFFE);
        send_read(16'h0020);
        send_read(16'h0004);
        send_read('0);
        send_read('0);
        // rest of the aborted run dropped up to its last word
        send_word(OP_PROGRAM, 24'h000010, 16'h5A5A, '0, 1'b0);
        send_word(OP_PROGRAM, 24'h000011, 16'h5A5A, '0, 1'b1);
        // abort again, then an erase ends it
        send_word(OP_PROGRAM, 24'h000020, '0, '0, 1'b0);
        send_read(16'h0001);
        send_read(16'h0004);
        send_read('0);
        send_word(OP_SECTOR_ERASE, '1, '0, '0, 1'b0);
        send_word(OP_CHIP_ERASE, '0, '0, '0, 1'b0);
        // DQ5 set and both pairs toggle: device error
        send_read(16'h0020);
        send_read(16'h0044);
        send_read('0);
        send_read(16'h0044);
        settle();
    endtask

    task automatic run_random(input logic [LIMIT_W-1:0] limit, input int tx, input int rx,
                              input bit long_hold);
        int stop_at;
        set_poll_limit(limit);
        tx_idle = tx;
        rx_idle = rx;
        if (long_hold)
            hold_off_req = 1'b1;
        stop_at = sent_words + PHASE_WORDS;
        while (sent_words < stop_at)
            random_sequence();
        settle();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cmd.valid          = 1'b0;
        cmd.operation      = OP_READ_DATA;
        cmd.target_address = '0;
        cmd.write_halfword = '0;
        cmd.read_halfword  = '0;
        cmd.last_word      = 1'b0;
        cfg.valid          = 1'b0;
        cfg.poll_limit     = '0;
        tx_idle            = 27;
        rx_idle            = 79;
        hold_off_req       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random(24'd1, 27, 79, 1'b1);
        run_random(24'd2, 79, 27, 1'b0);
        run_random('1, 0, 0, 1'b0);
        run_random(LIMIT_W'($urandom_range(3, 6)), 0, 0, 1'b0);

        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
